/* src/gsv_pkg.sv */
// Shared types and constants for the growable stack vector.
package gsv_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned Depth   = 256;
  localparam int unsigned AddrW   = 8;   // word store address
  localparam int unsigned CntW    = 9;   // count and capacity, can hold Depth
  localparam int unsigned OpW     = 2;
  localparam int unsigned StW     = 2;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;
  localparam int unsigned FifoDepth = 3;
  localparam int unsigned PtrW    = 2;
  localparam int unsigned LvlW    = 2;

  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [CntW-1:0] InitCapRst = 9'd16;
  localparam logic [CntW-1:0] BlockRst   = 9'd8;

  typedef enum logic [OpW-1:0] {
    OpPush = 2'd0,
    OpPop  = 2'd1,
    OpGet  = 2'd2,
    OpSet  = 2'd3
  } op_e;

  typedef enum logic [StW-1:0] {
    StOk    = 2'd0,
    StUnder = 2'd1,
    StOver  = 2'd2,
    StAlloc = 2'd3
  } status_e;

  // register index, taken from paddr[2]
  typedef enum logic {
    RegInitCap   = 1'b0,
    RegBlockSize = 1'b1
  } reg_e;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] read_value;
    logic [CntW-1:0]         item_count;
    logic [CntW-1:0]         capacity_now;
  } res_t;

endpackage

/* src/gsv_req_if.sv */
// Request channel: one vector operation per transfer.
interface gsv_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [gsv_pkg::OpW-1:0]              opcode;
  logic [gsv_pkg::CntW-1:0]             index;
  logic signed [gsv_pkg::DataW-1:0]     value;

  modport source (output valid, opcode, index, value, input ready);
  modport sink   (input valid, opcode, index, value, output ready);
endinterface

/* src/gsv_rsp_if.sv */
// Response channel: one result per operation.
interface gsv_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [gsv_pkg::StW-1:0]              status;
  logic signed [gsv_pkg::DataW-1:0]     read_value;
  logic [gsv_pkg::CntW-1:0]             item_count;
  logic [gsv_pkg::CntW-1:0]             capacity_now;

  modport source (output valid, status, read_value, item_count, capacity_now, input ready);
  modport sink   (input valid, status, read_value, item_count, capacity_now, output ready);
endinterface

/* src/gsv_res_fifo.sv */
// Small result FIFO that decouples the response channel from the request side.
module gsv_res_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  gsv_pkg::res_t                push_data_i,
  input  logic                         pop_i,
  output gsv_pkg::res_t                data_o,
  output logic                         valid_o,
  output logic [gsv_pkg::LvlW-1:0]     level_o
);

  gsv_pkg::res_t ent_q [gsv_pkg::FifoDepth];
  logic [gsv_pkg::PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [gsv_pkg::PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [gsv_pkg::LvlW-1:0] level_q, level_d;
  logic                     pop;

  localparam logic [gsv_pkg::PtrW-1:0] LastPtr = gsv_pkg::PtrW'(gsv_pkg::FifoDepth - 1);

  assign pop = pop_i && (level_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      level_d = level_q + 1'b1;
    end else if (!push_i && pop) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign data_o  = ent_q[rd_ptr_q];
  assign valid_o = (level_q != '0);
  assign level_o = level_q;

endmodule

/* src/growable_stack_vector.sv */
// Top level of the growable stack vector: control, word store and result path.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-----------------------------------------------
//   req_i    | in  | valid/ready      | opcode, index, value
//   rsp_o    | out | valid/ready      | status, read_value, item_count, capacity_now
//   APB      | in  | psel/penable     | paddr 0: initial_capacity, 4: block_size
//
// One operation per cycle while req_i.ready is high; each result passes the result
// register (with the word store read register), then the result FIFO.
// Count, capacity and the store are updated in the cycle of the transfer.
// req_i.ready drops only when the result register and the 3-entry FIFO hold
// three results between them; rsp_o stalls never lose or repeat a result.
// Reset clears count to zero and capacity to 16; the store is not cleared.
module growable_stack_vector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gsv_req_if.sink                         req_i,
  gsv_rsp_if.source                       rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gsv_pkg::PaddrW-1:0]      paddr,
  input  logic [gsv_pkg::PdataW-1:0]      pwdata,
  output logic [gsv_pkg::PdataW-1:0]      prdata,
  output logic                            pready
);

  // configuration
  logic [gsv_pkg::CntW-1:0] init_cap_q, block_q;
  logic                     cfg_we;
  gsv_pkg::reg_e            cfg_sel;
  logic [gsv_pkg::CntW-1:0] cfg_val;
  logic [gsv_pkg::CntW-1:0] floor_new;

  // vector state
  logic [gsv_pkg::CntW-1:0] count_q, count_d;
  logic [gsv_pkg::CntW-1:0] cap_q, cap_d;
  logic [gsv_pkg::CntW-1:0] floor_cap;

  // operation decode
  logic                      req_fire;
  gsv_pkg::op_e              op;
  gsv_pkg::status_e          status;
  logic                      rd_flag;
  logic                      mem_we, mem_re;
  logic [gsv_pkg::AddrW-1:0] mem_waddr, mem_raddr;
  logic [gsv_pkg::CntW-1:0]  cnt_m1, idx_m1, slack, shrunk;
  logic [gsv_pkg::CntW:0]    grown;

  // word store
  logic signed [gsv_pkg::DataW-1:0] mem_q [gsv_pkg::Depth];
  logic signed [gsv_pkg::DataW-1:0] rdata_q;

  // result register
  logic                      a_valid_q;
  gsv_pkg::status_e          a_status_q;
  logic                      a_rd_q;
  logic [gsv_pkg::CntW-1:0]  a_count_q, a_cap_q;
  gsv_pkg::res_t             a_res;

  // result FIFO
  gsv_pkg::res_t             fifo_data;
  logic                      fifo_valid, fifo_pop;
  logic [gsv_pkg::LvlW-1:0]  fifo_level;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_sel = gsv_pkg::reg_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_val = pwdata[gsv_pkg::CntW-1:0];
  assign floor_new = (cfg_val > gsv_pkg::DepthCnt) ? gsv_pkg::DepthCnt : cfg_val;

  always_comb begin
    unique case (cfg_sel)
      gsv_pkg::RegInitCap:   prdata = {{(gsv_pkg::PdataW-gsv_pkg::CntW){1'b0}}, init_cap_q};
      gsv_pkg::RegBlockSize: prdata = {{(gsv_pkg::PdataW-gsv_pkg::CntW){1'b0}}, block_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------- operation ----------------
  assign req_i.ready = ({1'b0, fifo_level} + {{gsv_pkg::LvlW{1'b0}}, a_valid_q})
                       < (gsv_pkg::LvlW+1)'(gsv_pkg::FifoDepth);
  assign req_fire    = req_i.valid && req_i.ready;
  assign op          = gsv_pkg::op_e'(req_i.opcode);

  assign floor_cap = (init_cap_q > gsv_pkg::DepthCnt) ? gsv_pkg::DepthCnt : init_cap_q;
  assign grown     = {1'b0, cap_q} + {1'b0, block_q};
  assign cnt_m1    = count_q - 1'b1;
  assign idx_m1    = req_i.index - 1'b1;
  assign slack     = cap_q - cnt_m1;
  // shrink by one block, clamped at zero and raised to the floor
  assign shrunk    = (cap_q > block_q) ? (cap_q - block_q) : '0;

  always_comb begin
    count_d   = count_q;
    cap_d     = cap_q;
    status    = gsv_pkg::StOk;
    rd_flag   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = count_q[gsv_pkg::AddrW-1:0];
    mem_raddr = cnt_m1[gsv_pkg::AddrW-1:0];
    unique case (op)
      gsv_pkg::OpPush: begin
        if (count_q >= cap_q) begin
          if (block_q == '0) begin
            status = gsv_pkg::StOver;
          end else if (grown > {1'b0, gsv_pkg::DepthCnt}) begin
            status = gsv_pkg::StAlloc;
          end else begin
            cap_d   = grown[gsv_pkg::CntW-1:0];
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end else begin
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      gsv_pkg::OpPop: begin
        if (count_q == '0) begin
          status = gsv_pkg::StUnder;
        end else begin
          count_d = cnt_m1;
          mem_re  = 1'b1;
          rd_flag = 1'b1;
          if (block_q != '0 && {2'b00, slack} > {1'b0, block_q, 1'b0}) begin
            cap_d = (shrunk < floor_cap) ? floor_cap : shrunk;
          end
        end
      end
      gsv_pkg::OpGet, gsv_pkg::OpSet: begin
        mem_waddr = idx_m1[gsv_pkg::AddrW-1:0];
        mem_raddr = idx_m1[gsv_pkg::AddrW-1:0];
        if (req_i.index == '0) begin
          status = gsv_pkg::StUnder;
        end else if (req_i.index > count_q) begin
          status = gsv_pkg::StOver;
        end else if (op == gsv_pkg::OpGet) begin
          mem_re  = 1'b1;
          rd_flag = 1'b1;
        end else begin
          mem_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cap_q <= gsv_pkg::InitCapRst;
      block_q    <= gsv_pkg::BlockRst;
      count_q    <= '0;
      cap_q      <= gsv_pkg::InitCapRst;
      a_valid_q  <= 1'b0;
    end else begin
      a_valid_q <= req_fire;
      if (cfg_we && cfg_sel == gsv_pkg::RegInitCap) begin
        // restart the vector; stored words stay
        init_cap_q <= cfg_val;
        count_q    <= '0;
        cap_q      <= floor_new;
      end else if (req_fire) begin
        count_q <= count_d;
        cap_q   <= cap_d;
      end
      if (cfg_we && cfg_sel == gsv_pkg::RegBlockSize) begin
        block_q <= cfg_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      a_status_q <= status;
      a_rd_q     <= rd_flag;
      a_count_q  <= count_d;
      a_cap_q    <= cap_d;
    end
  end

  // word store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (req_fire && mem_we) begin
      mem_q[mem_waddr] <= req_i.value;
    end
    if (req_fire && mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign a_res.status       = a_status_q;
  assign a_res.read_value   = a_rd_q ? rdata_q : '0;
  assign a_res.item_count   = a_count_q;
  assign a_res.capacity_now = a_cap_q;

  // ---------------- result path ----------------
  assign fifo_pop = rsp_o.ready && fifo_valid;

  gsv_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (a_valid_q),
    .push_data_i (a_res),
    .pop_i       (fifo_pop),
    .data_o      (fifo_data),
    .valid_o     (fifo_valid),
    .level_o     (fifo_level)
  );

  assign rsp_o.valid        = fifo_valid;
  assign rsp_o.status       = fifo_data.status;
  assign rsp_o.read_value   = fifo_data.read_value;
  assign rsp_o.item_count   = fifo_data.item_count;
  assign rsp_o.capacity_now = fifo_data.capacity_now;

`ifndef SYNTHESIS
  // the credit check on req_i.ready must keep the FIFO from overrunning
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !fifo_pop) |-> (fifo_level != (gsv_pkg::LvlW)'(gsv_pkg::FifoDepth)))
    else $error("result FIFO overrun");

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= cap_q)
    else $error("count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cap_q <= gsv_pkg::DepthCnt)
    else $error("capacity above store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && op == gsv_pkg::OpPop && count_q != '0 && !cfg_we)
      |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not remove one item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> a_valid_q)
    else $error("transfer without result");
`endif

endmodule
